// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the tone generator.
// No dependencies; each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/stg_pkg.sv =====
// Package for the sawtooth tone generator: action codes, widths and the
// waveform table function. No dependencies.
package stg_pkg;

    // Transaction action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_PITCH  = 2'd1;
    localparam logic [1:0] ACT_VOLUME = 2'd2;

    // Substeps per sample; must stay a power of two
    localparam int SUBSTEP_SHIFT = 4;
    localparam int SUBSTEPS      = 1 << SUBSTEP_SHIFT;

    // Accumulator holds SUBSTEPS signed 8-bit entries
    localparam int SUM_W = 8 + SUBSTEP_SHIFT;

    // Silent pitch: a tick gives zero and leaves the state alone
    localparam logic [7:0] PITCH_SILENT = 8'hff;

    typedef logic signed [SUM_W-1:0] sum_t;

    // Waveform entry from bits 0, 2 and 3 of the index, biased by -0x80
    function automatic logic signed [7:0] wave_entry(input logic [1:0] sel,
                                                     input logic [3:0] idx);
        logic [8:0] raw;
        logic [8:0] w2;
        logic [8:0] w3;
        begin
            w2  = sel[0] ? 9'h099 : 9'h030;
            w3  = sel[1] ? 9'h046 : 9'h000;
            raw = (idx[0] ? 9'h020 : 9'h000) + (idx[2] ? w2 : 9'h000)
                + (idx[3] ? w3 : 9'h000);
            wave_entry = 8'(raw - 9'h080);
        end
    endfunction

endpackage

// ===== hdl/sawtooth_tone_generator_unit.sv =====
// Sawtooth tone generator: top level with sequencer and shared accumulator.
// Depends on stg_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: action,
//   write_value and bit_select. A pitch write or a volume-bit write takes
//   effect in the accepting cycle and gives no result. A tick (action 0)
//   produces one signed sample on the output channel (out_valid /
//   out_stall, sample).
//   A tick runs SUBSTEPS (16) substeps through one phase counter, one
//   waveform lookup and one accumulator, one substep per clock. S_DONE
//   then moves the average into the output register; a tick with pitch
//   0xff goes from idle straight to S_DONE and gives zero.
//   in_stall is high while a tick is in progress, so nothing new is taken
//   until the tick leaves S_DONE. A finished sample sits in the output
//   register; the input stays open while it waits, and a following tick
//   completes its substeps and holds until the receiver lifts out_stall.
//   Reset clears pitch, waveform choice, wave index and phase counter and
//   empties the output register.
`include "assert_macros.svh"

module sawtooth_tone_generator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [7:0]        write_value,
    input  logic              bit_select,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] sample
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                                 state_reg, state_next;
    logic [7:0]                             pitch_reg, pitch_next;
    logic [1:0]                             wsel_reg, wsel_next;
    logic [3:0]                             wpos_reg, wpos_next;
    logic [8:0]                             phase_reg, phase_next;
    logic [stg_pkg::SUBSTEP_SHIFT-1:0]      cnt_reg, cnt_next;
    stg_pkg::sum_t                          sum_reg, sum_next;
    logic                                   ovalid_reg, ovalid_next;
    logic signed [7:0]                      sample_reg, sample_next;

    logic          in_fire;
    logic          out_free;
    logic [3:0]    pos_eff;
    logic [8:0]    phase_eff;
    stg_pkg::sum_t sum_adj;
    stg_pkg::sum_t avg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;
    assign out_valid = ovalid_reg;
    assign sample    = sample_reg;

    // Substep datapath: advance the wave index when the counter has hit 256
    assign pos_eff   = phase_reg[8] ? wpos_reg + 4'd1 : wpos_reg;
    assign phase_eff = phase_reg[8] ? {1'b0, pitch_reg} : phase_reg;

    // Average with truncation toward zero
    assign sum_adj = sum_reg + (sum_reg[stg_pkg::SUM_W-1]
                     ? stg_pkg::SUM_W'(stg_pkg::SUBSTEPS - 1) : '0);
    assign avg     = sum_adj >>> stg_pkg::SUBSTEP_SHIFT;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next  = state_reg;
        pitch_next  = pitch_reg;
        wsel_next   = wsel_reg;
        wpos_next   = wpos_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        ovalid_next = ovalid_reg && out_stall;
        sample_next = sample_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        stg_pkg::ACT_PITCH:
                        begin
                            pitch_next = write_value;
                        end
                        stg_pkg::ACT_VOLUME:
                        begin
                            wsel_next[bit_select] = write_value[0];
                        end
                        stg_pkg::ACT_TICK:
                        begin
                            sum_next = '0;
                            cnt_next = '0;
                            if (pitch_reg == stg_pkg::PITCH_SILENT)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                wpos_next  = pos_eff;
                phase_next = phase_eff + 9'd1;
                sum_next   = sum_reg + stg_pkg::SUM_W'(stg_pkg::wave_entry(wsel_reg, pos_eff));
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == stg_pkg::SUBSTEP_SHIFT'(stg_pkg::SUBSTEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register can take the sample
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    sample_next = avg[7:0];
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pitch_reg  <= '0;
            wsel_reg   <= '0;
            wpos_reg   <= '0;
            phase_reg  <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pitch_reg  <= pitch_next;
            wsel_reg   <= wsel_next;
            wpos_reg   <= wpos_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        sample_reg <= sample_next;
    end

    // Checks on the sequencer and phase counter
    `ASSERT_NEVER(a_phase_max, clk, rst_n, phase_reg[8] && (phase_reg[7:0] != 8'd0), "phase counter above 256")
    `ASSERT_PROP(a_run_exit, clk, rst_n, (state_reg == S_RUN) |=> (state_reg == S_RUN || state_reg == S_DONE), "run left to an unexpected state")
    `ASSERT_PROP(a_out_src, clk, rst_n, $rose(ovalid_reg) |-> $past(state_reg == S_DONE), "sample appeared outside completion")
    `ASSERT_PROP(a_silent, clk, rst_n, (in_fire && action == stg_pkg::ACT_TICK && pitch_reg == stg_pkg::PITCH_SILENT) |=> ($stable(wpos_reg) && $stable(phase_reg) && sum_reg == '0), "silent tick changed state")

endmodule

// ===== dv/stg_sample_checker.sv =====
// Sample checker for the sawtooth tone generator testbench: follows the tone
// state from accepted transactions, predicts each sample and compares it.
// Depends on stg_pkg (action codes, silent pitch, substep count).
module stg_sample_checker
    import stg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        action,
    input  logic [7:0]        write_value,
    input  logic              bit_select,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic signed [7:0] sample,
    output int                errors,
    output int                pending,
    output int                samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tone state as the block should hold it
    logic [7:0]        pitch_q;
    logic [1:0]        shape_q;
    logic [3:0]        pos_q;
    logic [8:0]        phase_q;
    logic signed [7:0] sample_queue[$];

    // Level of one waveform step: bits 0, 2 and 3 of the position add weight
    function automatic int tone_level(input logic [1:0] shape, input logic [3:0] pos);
        int lvl;
        lvl = -128;
        if (pos[0])
            lvl += 32;
        if (pos[2])
            lvl += shape[0] ? 153 : 48;
        if (pos[3] && shape[1])
            lvl += 70;
        return lvl;
    endfunction

    // Run the substeps of one tick and average them; silent pitch holds state
    task automatic run_tick(output logic signed [7:0] level);
        int acc;
        acc = 0;
        if (pitch_q == PITCH_SILENT)
        begin
            level = '0;
            return;
        end
        for (int s = 0; s < SUBSTEPS; s++)
        begin
            if (phase_q >= 9'd256)
            begin
                pos_q   = pos_q + 4'd1;
                phase_q = {1'b0, pitch_q};
            end
            phase_q = phase_q + 9'd1;
            acc += tone_level(shape_q, pos_q);
        end
        level = 8'(acc / SUBSTEPS);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] sample check: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [7:0] predicted;
        if (!rst_n)
        begin
            pitch_q         = '0;
            shape_q         = '0;
            pos_q           = '0;
            phase_q         = '0;
            sample_queue    = {};
            errors          = 0;
            pending         = 0;
            samples_checked = 0;
        end
        else
        begin
            // Compare a delivered sample with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (sample_queue.size() == 0)
                    report_mismatch($sformatf("unexpected sample %0d", sample));
                else
                begin
                    if (sample !== sample_queue[0])
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  sample, sample_queue[0]));
                    void'(sample_queue.pop_front());
                    samples_checked++;
                end
            end
            // Advance the predicted state on an accepted transaction
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_PITCH:  pitch_q = write_value;
                    ACT_VOLUME: shape_q[bit_select] = write_value[0];
                    ACT_TICK:
                    begin
                        run_tick(predicted);
                        sample_queue.push_back(predicted);
                    end
                    default: ;
                endcase
            end
            pending = sample_queue.size();
        end
    end

endmodule

// ===== dv/sawtooth_tone_generator_unit_tb.sv =====
// Testbench top for the sawtooth tone generator: drives register writes and
// ticks under several idling mixes and gives the verdict.
// Depends on stg_pkg, stg_sample_checker and sawtooth_tone_generator_unit.
module sawtooth_tone_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int CYCLE_LIMIT          = 300000;
    localparam int HOLD_CYCLES          = 400;
    localparam int ITEMS_PER_PHASE      = 180;
    localparam int DRAIN_CYCLES         = 40;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [1:0]        action      = ACT_TICK;
    logic [7:0]        write_value = '0;
    logic              bit_select  = 1'b0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic signed [7:0] sample;

    int errors;
    int pending;
    int samples_checked;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_used      = 1'b0;
    int   hold_left      = 0;
    int   cycle_count    = 0;

    int n_ticks  = 0;
    int n_pitch  = 0;
    int n_volume = 0;
    int n_unused = 0;

    sawtooth_tone_generator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .write_value(write_value),
        .bit_select (bit_select),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample)
    );

    stg_sample_checker sample_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .write_value    (write_value),
        .bit_select     (bit_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample         (sample),
        .errors         (errors),
        .pending        (pending),
        .samples_checked(samples_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output at random; take one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_used)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, pending);
            $display("[sawtooth_tone_generator_unit] ERROR");
            $finish;
        end
    end

    // Offer one transaction, hold it until accepted, then maybe idle
    task automatic send_item(input logic [1:0] act, input logic [7:0] val,
                             input logic sel);
        in_valid    <= 1'b1;
        action      <= act;
        write_value <= val;
        bit_select  <= sel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (act)
            ACT_TICK:   n_ticks++;
            ACT_PITCH:  n_pitch++;
            ACT_VOLUME: n_volume++;
            default:    n_unused++;
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Ticks half the time; pitch leans towards high values so the wave moves fast
    task automatic send_random_item();
        int         pick;
        logic [7:0] val;
        pick = $urandom_range(99);
        if (pick < 50)
            send_item(ACT_TICK, 8'($urandom), 1'($urandom));
        else if (pick < 70)
        begin
            case ($urandom_range(2))
                0:       val = 8'($urandom_range(255, 240));
                1:       val = 8'($urandom_range(255, 192));
                default: val = 8'($urandom);
            endcase
            send_item(ACT_PITCH, val, 1'($urandom));
        end
        else if (pick < 94)
            send_item(ACT_VOLUME, 8'($urandom), 1'($urandom));
        else
            send_item(ACT_UNUSED, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = n_ticks + n_pitch + n_volume + ITEMS_PER_PHASE;
        while (n_ticks + n_pitch + n_volume < target)
            send_random_item();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, every waveform, high pitch, silent pitch
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_PITCH, 8'h00, 1'b0);
        send_item(ACT_TICK, 8'hff, 1'b1);
        // only bit 0 of a volume write counts
        send_item(ACT_VOLUME, 8'hff, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_VOLUME, 8'h01, 1'b1);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_VOLUME, 8'hfe, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        // pitch 0xfe: the wave advances every second substep once the phase reaches 256
        send_item(ACT_PITCH, 8'hfe, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_PITCH, PITCH_SILENT, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_UNUSED, 8'haa, 1'b1);
        send_item(ACT_UNUSED, 8'h55, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_VOLUME, 8'h54, 1'b1);
        send_item(ACT_PITCH, 8'h80, 1'b1);
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_PITCH, 8'h01, 1'b0);
        send_item(ACT_TICK, 8'h00, 1'b0);

        // Random phases: free flow, idle sender, stalling receiver, light mix
        run_phase(0, 0);
        run_phase(82, 0);
        run_phase(0, 82);
        run_phase(14, 14);

        // Hold the output off for a long stretch while ticks keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req      <= 1'b1;
        send_item(ACT_PITCH, 8'h40, 1'b0);
        repeat (40)
            send_item(ACT_TICK, 8'($urandom), 1'($urandom));
        hold_req <= 1'b0;

        // Drain outstanding samples
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d ticks, %0d pitch writes, %0d volume writes, %0d unused",
                 n_ticks, n_pitch, n_volume, n_unused);
        $display("%0d samples compared, %0d mismatches, long output hold-off taken: %0b",
                 samples_checked, errors, hold_used);
        if (errors == 0 && pending == 0)
            $display("[sawtooth_tone_generator_unit] OK");
        else
            $display("[sawtooth_tone_generator_unit] ERROR");
        $finish;
    end

endmodule
